@@ design/assert_macros.svh @@
// Assertion macros shared by the checker files of this project.
// Each macro expands to one labeled concurrent assertion clocked on a rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, off during reset.
`define MWC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle, off during reset.
`define MWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle, checked through reset too.
`define MWC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mwc_pkg.sv @@
// Package for the median window calibrator: payload types and fixed widths.
// No dependencies; used by the top level and its checker.
package mwc_pkg;

    localparam int SAMPLE_BITS   = 10;
    localparam int FRACTION_BITS = 4;
    localparam int TBL_ADDR_BITS = SAMPLE_BITS - FRACTION_BITS;
    localparam int TABLE_DEPTH   = 1 << TBL_ADDR_BITS;
    localparam int CAL_BITS      = 16;

    typedef enum logic {
        OP_SAMPLE      = 1'b0,
        OP_TABLE_WRITE = 1'b1
    } t_op;

    typedef struct packed {
        t_op                      operation;
        logic [SAMPLE_BITS-1:0]   sample;
        logic [TBL_ADDR_BITS-1:0] table_index;
        logic [CAL_BITS-1:0]      table_value;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] median_raw;
        logic [CAL_BITS-1:0]    calibrated;
    } t_out_item;

endpackage

@@ design/mwc_ram.sv @@
// Generic single-write RAM with two registered read ports.
// No dependencies; holds the calibration table of the median window calibrator.
module mwc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data_a;
    logic [WIDTH-1:0] r_rd_data_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data_a <= r_mem[i_rd_addr_a];
            r_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;

endmodule

@@ design/median_window_calibrator.sv @@
// Median window calibrator: running median of converter samples, then table calibration.
// Depends on mwc_pkg and mwc_ram.
//
// Each sample beat shifts into a window of the most recent WINDOW_LENGTH samples (all zero
// after reset) and yields one result beat with the window median and its calibrated value.
// A table-write beat stores one calibration entry and yields no result; it affects every
// sample accepted after it and none accepted before it. The block takes one beat per cycle
// while the output is not stalled; each sample passes through the four-register pipeline
// (window, median, table read, result), with the calibration RAM addressed from the median
// register and its read data registered in the third stage. A stalled result holds every
// stage and the input. A calibration entry that has never been written reads as an unknown
// value.
module median_window_calibrator #(
    parameter int WINDOW_LENGTH = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mwc_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mwc_pkg::t_out_item o_out_data
);

    localparam int SB = mwc_pkg::SAMPLE_BITS;
    localparam int FB = mwc_pkg::FRACTION_BITS;
    localparam int AB = mwc_pkg::TBL_ADDR_BITS;
    localparam int CB = mwc_pkg::CAL_BITS;
    localparam int CNT_W = $clog2(WINDOW_LENGTH);
    localparam logic [CNT_W-1:0] MID_RANK = CNT_W'(WINDOW_LENGTH / 2);

    logic advance;
    logic accept;

    logic [SB-1:0]        r_win [WINDOW_LENGTH];

    logic                 r_s1_valid;
    mwc_pkg::t_op         r_s1_op;
    logic [AB-1:0]        r_s1_index;
    logic [CB-1:0]        r_s1_value;

    logic                 r_s2_valid;
    mwc_pkg::t_op         r_s2_op;
    logic [AB-1:0]        r_s2_index;
    logic [CB-1:0]        r_s2_value;
    logic [SB-1:0]        r_s2_median;

    logic                 r_s3_valid;
    logic [SB-1:0]        r_s3_median;
    logic [FB-1:0]        r_s3_frac;
    logic                 r_s3_idx_zero;

    logic                 r_out_valid;
    mwc_pkg::t_out_item   r_out_data;

    logic [WINDOW_LENGTH-1:0] below [WINDOW_LENGTH];
    logic [CNT_W-1:0]     rank [WINDOW_LENGTH];
    logic [SB-1:0]        n_median;

    logic [AB-1:0]        lookup_idx;
    logic [AB-1:0]        nbr_idx;
    logic                 tbl_wr_en;
    logic [CB-1:0]        tbl_base;
    logic [CB-1:0]        tbl_nbr;

    logic [CB-1:0]        slope;
    logic [CB+FB-1:0]     product;
    logic [CB-1:0]        n_calibrated;

    assign advance    = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && advance;
    assign o_in_ready = advance;

    // Rank of each window entry; ties are broken by position so exactly one entry
    // holds the middle rank.
    always_comb begin
        n_median = '0;
        for (int i = 0; i < WINDOW_LENGTH; i++) begin
            for (int j = 0; j < WINDOW_LENGTH; j++) begin
                below[i][j] = (r_win[j] < r_win[i]) || ((r_win[j] == r_win[i]) && (j < i));
            end
            rank[i] = CNT_W'($countones(below[i]));
            if (rank[i] == MID_RANK) begin
                n_median = n_median | r_win[i];
            end
        end
    end

    assign lookup_idx = r_s2_median[SB-1 -: AB];
    assign nbr_idx    = (lookup_idx == '0) ? AB'(1) : (lookup_idx - AB'(1));
    assign tbl_wr_en  = advance && r_s2_valid && (r_s2_op == mwc_pkg::OP_TABLE_WRITE);

    mwc_ram #(
        .WIDTH (CB),
        .DEPTH (mwc_pkg::TABLE_DEPTH)
    ) u_mwc_ram (
        .i_clk       (i_clk),
        .i_wr_en     (tbl_wr_en),
        .i_wr_addr   (r_s2_index),
        .i_wr_data   (r_s2_value),
        .i_rd_en     (advance),
        .i_rd_addr_a (lookup_idx),
        .i_rd_addr_b (nbr_idx),
        .o_rd_data_a (tbl_base),
        .o_rd_data_b (tbl_nbr)
    );

    assign slope        = r_s3_idx_zero ? (tbl_nbr - tbl_base) : (tbl_base - tbl_nbr);
    assign product      = (CB + FB)'(slope) * (CB + FB)'(r_s3_frac);
    assign n_calibrated = (product[CB-1:0] >> FB) + tbl_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < WINDOW_LENGTH; k++) begin
                r_win[k] <= '0;
            end
        end else if (advance) begin
            r_s1_valid  <= i_in_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid && (r_s2_op == mwc_pkg::OP_SAMPLE);
            r_out_valid <= r_s3_valid;
            if (accept && (i_in_data.operation == mwc_pkg::OP_SAMPLE)) begin
                for (int k = WINDOW_LENGTH - 1; k > 0; k--) begin
                    r_win[k] <= r_win[k-1];
                end
                r_win[0] <= i_in_data.sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_op       <= i_in_data.operation;
            r_s1_index    <= i_in_data.table_index;
            r_s1_value    <= i_in_data.table_value;
            r_s2_op       <= r_s1_op;
            r_s2_index    <= r_s1_index;
            r_s2_value    <= r_s1_value;
            r_s2_median   <= n_median;
            r_s3_median   <= r_s2_median;
            r_s3_frac     <= r_s2_median[FB-1:0];
            r_s3_idx_zero <= (lookup_idx == '0);
            r_out_data.median_raw <= r_s3_median;
            r_out_data.calibrated <= n_calibrated;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ design/mwc_checker.sv @@
// Port-level checker for the median window calibrator, attached by bind.
// Depends on mwc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mwc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input mwc_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input mwc_pkg::t_out_item o_out_data
);

    logic out_stall;
    logic sample_accept;

    assign out_stall     = o_out_valid && !i_out_ready;
    assign sample_accept = i_in_valid && o_in_ready
                           && (i_in_data.operation == mwc_pkg::OP_SAMPLE);

    `MWC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall,
        o_out_valid && $stable(o_out_data), "Stalled result beat changed or dropped.")
    `MWC_ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready,
        "Input stalled while the result register is empty.")
    `MWC_ASSERT_NEXT(a_sample_latency, i_clk, i_rst_n,
        sample_accept ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready, o_out_valid,
        "Sample beat gave no result within four cycles.")
    `MWC_ASSERT_NEXT_ALWAYS(a_empty_after_reset, i_clk, !i_rst_n, !o_out_valid,
        "Result valid right after reset.")

endmodule

bind median_window_calibrator mwc_checker u_mwc_checker (.*);

@@ tb/sv/mwc_reading_monitor.sv @@
// Reading monitor for the median window calibrator: watches both beat channels.
// Predicts each reading from its own sample window and calibration table copy.
// Depends on mwc_pkg.
module mwc_reading_monitor #(
    parameter int WINDOW_LENGTH = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  mwc_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  mwc_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_samples,
    output int                 o_writes,
    output int                 o_readings
);

    logic [mwc_pkg::SAMPLE_BITS-1:0] sample_history [WINDOW_LENGTH];
    logic [mwc_pkg::CAL_BITS-1:0]    cal_entries [mwc_pkg::TABLE_DEPTH];
    mwc_pkg::t_out_item              pending_readings [$];

    function automatic logic [mwc_pkg::SAMPLE_BITS-1:0] history_median();
        int below;
        int at_most;
        logic [mwc_pkg::SAMPLE_BITS-1:0] mid;
        mid = '0;
        for (int a = 0; a < WINDOW_LENGTH; a++) begin
            below   = 0;
            at_most = 0;
            for (int b = 0; b < WINDOW_LENGTH; b++) begin
                if (sample_history[b] < sample_history[a]) below++;
                if (sample_history[b] <= sample_history[a]) at_most++;
            end
            if (below <= WINDOW_LENGTH / 2 && at_most > WINDOW_LENGTH / 2) begin
                mid = sample_history[a];
            end
        end
        return mid;
    endfunction

    function automatic logic [mwc_pkg::CAL_BITS-1:0] predict_calibrated(
            input logic [mwc_pkg::SAMPLE_BITS-1:0] mid);
        logic [mwc_pkg::TBL_ADDR_BITS-1:0] entry;
        logic [mwc_pkg::FRACTION_BITS-1:0] frac;
        logic [mwc_pkg::CAL_BITS-1:0]      base;
        logic [mwc_pkg::CAL_BITS-1:0]      slope;
        logic [mwc_pkg::CAL_BITS-1:0]      prod;
        entry = mid[mwc_pkg::SAMPLE_BITS-1:mwc_pkg::FRACTION_BITS];
        frac  = mid[mwc_pkg::FRACTION_BITS-1:0];
        base  = cal_entries[entry];
        if (entry != '0) begin
            slope = base - cal_entries[entry - 1'b1];
        end else begin
            slope = cal_entries[1] - base;
        end
        prod = slope * frac;
        return base + (prod >> mwc_pkg::FRACTION_BITS);
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_samples    = 0;
        o_writes     = 0;
        o_readings   = 0;
        foreach (cal_entries[k]) cal_entries[k] = '0;
    end

    always @(posedge i_clk) begin
        mwc_pkg::t_out_item want;
        mwc_pkg::t_out_item fresh;
        if (!i_rst_n) begin
            foreach (sample_history[k]) sample_history[k] = '0;
            pending_readings.delete();
        end else begin
            // Results always trail their sample, so compare first.
            if (i_out_valid && i_out_ready) begin
                o_readings++;
                if (pending_readings.size() == 0) begin
                    $error("result beat with no reading expected: median_raw %0d calibrated 0x%04h",
                           i_out_data.median_raw, i_out_data.calibrated);
                    o_fail_count++;
                end else begin
                    want = pending_readings.pop_front();
                    if (i_out_data.median_raw !== want.median_raw) begin
                        $error("median_raw mismatch: expected %0d, actual %0d",
                               want.median_raw, i_out_data.median_raw);
                        o_fail_count++;
                    end
                    if (i_out_data.calibrated !== want.calibrated) begin
                        $error("calibrated mismatch: expected 0x%04h, actual 0x%04h",
                               want.calibrated, i_out_data.calibrated);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.operation == mwc_pkg::OP_TABLE_WRITE) begin
                    cal_entries[i_in_data.table_index] = i_in_data.table_value;
                    o_writes++;
                end else begin
                    for (int k = WINDOW_LENGTH - 1; k > 0; k--) begin
                        sample_history[k] = sample_history[k - 1];
                    end
                    sample_history[0]  = i_in_data.sample;
                    fresh.median_raw   = history_median();
                    fresh.calibrated   = predict_calibrated(fresh.median_raw);
                    pending_readings.push_back(fresh);
                    o_samples++;
                end
            end
        end
        o_pending = pending_readings.size();
    end

endmodule

@@ tb/sv/tb_median_window_calibrator.sv @@
// Testbench top for the median window calibrator: clock, reset, beat stimulus and verdict.
// Depends on mwc_pkg, median_window_calibrator and mwc_reading_monitor.
module tb_median_window_calibrator;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 120;
    localparam int PHASE_BEATS  = 222;
    localparam int DRAIN_CYCLES = 12;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    mwc_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    mwc_pkg::t_out_item o_out_data;

    int fail_count;
    int pending;
    int samples_seen;
    int writes_seen;
    int readings_seen;
    int cycle_count;
    int tx_idle_pct;
    int rx_idle_pct;
    bit out_hold_req;
    int drift_center;

    median_window_calibrator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    mwc_reading_monitor monitor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_samples   (samples_seen),
        .o_writes    (writes_seen),
        .o_readings  (readings_seen)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic mwc_pkg::t_in_item sample_beat(
            input logic [mwc_pkg::SAMPLE_BITS-1:0] value);
        mwc_pkg::t_in_item beat;
        beat.operation   = mwc_pkg::OP_SAMPLE;
        beat.sample      = value;
        beat.table_index = mwc_pkg::TBL_ADDR_BITS'($urandom);
        beat.table_value = mwc_pkg::CAL_BITS'($urandom);
        return beat;
    endfunction

    function automatic mwc_pkg::t_in_item write_beat(
            input logic [mwc_pkg::TBL_ADDR_BITS-1:0] entry,
            input logic [mwc_pkg::CAL_BITS-1:0] value);
        mwc_pkg::t_in_item beat;
        beat.operation   = mwc_pkg::OP_TABLE_WRITE;
        beat.sample      = mwc_pkg::SAMPLE_BITS'($urandom);
        beat.table_index = entry;
        beat.table_value = value;
        return beat;
    endfunction

    // Mostly samples; a drifting center keeps the median moving through neighboring entries.
    function automatic mwc_pkg::t_in_item random_beat();
        int pick;
        int value;
        pick = $urandom_range(99);
        if (pick < 15) begin
            if ($urandom_range(9) == 0) begin
                return write_beat(mwc_pkg::TBL_ADDR_BITS'($urandom),
                                  $urandom_range(1) ? '1 : '0);
            end
            return write_beat(mwc_pkg::TBL_ADDR_BITS'($urandom), mwc_pkg::CAL_BITS'($urandom));
        end
        if (pick < 55) begin
            drift_center = drift_center + $urandom_range(64) - 32;
            if (drift_center < 0) drift_center = 0;
            if (drift_center > 1023) drift_center = 1023;
            value = drift_center + $urandom_range(16) - 8;
            if (value < 0) value = 0;
            if (value > 1023) value = 1023;
            return sample_beat(mwc_pkg::SAMPLE_BITS'(value));
        end
        if (pick < 65) begin
            return sample_beat($urandom_range(1) ? '1 : '0);
        end
        return sample_beat(mwc_pkg::SAMPLE_BITS'($urandom));
    endfunction

    task automatic send_beat(input mwc_pkg::t_in_item beat);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (out_hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                out_hold_req = 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_out_ready  = 1'b0;
        cycle_count  = 0;
        tx_idle_pct  = 32;
        rx_idle_pct  = 74;
        out_hold_req = 1'b0;
        drift_center = 512;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // The whole table is loaded before any sample, so no lookup hits an unwritten entry.
        // Entry zero gets a forward slope that wraps; the top entries wrap on interpolation.
        for (int k = 0; k < mwc_pkg::TABLE_DEPTH; k++) begin
            unique case (k)
                0:  send_beat(write_beat(mwc_pkg::TBL_ADDR_BITS'(k), 16'hFFFF));
                1:  send_beat(write_beat(mwc_pkg::TBL_ADDR_BITS'(k), 16'h0000));
                62: send_beat(write_beat(mwc_pkg::TBL_ADDR_BITS'(k), 16'h0001));
                63: send_beat(write_beat(mwc_pkg::TBL_ADDR_BITS'(k), 16'hFFFF));
                default: begin
                    send_beat(write_beat(mwc_pkg::TBL_ADDR_BITS'(k),
                                         mwc_pkg::CAL_BITS'($urandom)));
                end
            endcase
        end

        repeat (5) send_beat(sample_beat(10'd15));
        repeat (5) send_beat(sample_beat(10'd1023));
        repeat (5) send_beat(sample_beat(10'd0));
        send_beat(write_beat(6'd0, 16'h0000));
        send_beat(write_beat(6'd1, 16'hFFFF));
        send_beat(sample_beat(10'h2AA));
        send_beat(sample_beat(10'h155));
        send_beat(sample_beat(10'h00F));
        send_beat(sample_beat(10'h3F0));

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                tx_idle_pct = 74;
                rx_idle_pct = 32;
            end else if (phase == 2) begin
                tx_idle_pct  = 0;
                rx_idle_pct  = 0;
                out_hold_req = 1'b1;
            end
            repeat (PHASE_BEATS) send_beat(random_beat());
        end
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d readings from %0d samples, with %0d calibration table writes.",
                 readings_seen, samples_seen, writes_seen);
        $display("Traffic ran with idling on each side, a %0d-cycle output hold, then full rate.",
                 HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ median_window_calibrator.f @@
+incdir+design
design/mwc_pkg.sv
design/mwc_ram.sv
design/median_window_calibrator.sv
design/mwc_checker.sv
tb/sv/mwc_reading_monitor.sv
tb/sv/tb_median_window_calibrator.sv
